// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// antecedent holds -> consequent holds in the next cycle
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/mlfd_pkg.sv =====
package mlfd_pkg;

   localparam int MAGIC_LEN  = 5;
   localparam int LEN_DIGITS = 4;
   localparam int POS_W      = 3;
   localparam int LEN_W      = 14;
   localparam int PROD_W     = 18;
   localparam logic [LEN_W-1:0] ACC_MAX = 14'h3FFF;

   localparam logic [7:0] MAGIC_WORD [8] = '{
      8'h4B, 8'h69, 8'h69, 8'h69, 8'h6B, 8'h00, 8'h00, 8'h00
   };

   localparam logic KIND_BODY  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      PH_MAGIC = 2'd0,
      PH_LEN   = 2'd1,
      PH_BODY  = 2'd2,
      PH_DROP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] body_byte;
      logic       frame_last;
   } result_type;

endpackage

// ===== hdl/mlfd_parser.sv =====
`include "assert_macros.svh"

module mlfd_parser import mlfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       data_byte,
   input  logic             chunk_end,
   input  logic [LEN_W-1:0] max_body_len,
   input  logic             connected,
   output result_type       result
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] field_pos_ff, field_pos_in;
   logic [LEN_W-1:0] length_acc_ff, length_acc_in;
   logic             started_ff, started_in;
   logic             neg_ff, neg_in;
   logic             stopped_ff, stopped_in;
   logic [LEN_W-1:0] body_left_ff, body_left_in;

   logic              is_digit, is_blank, is_sign;
   logic [PROD_W-1:0] acc_prod;
   logic [LEN_W-1:0]  acc_upd;
   logic              started_upd, neg_upd, stopped_upd;
   logic              magic_bad, len_done, len_bad, body_last;

   assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
   assign is_blank = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
   assign is_sign  = (data_byte == 8'h2B) || (data_byte == 8'h2D);
   assign acc_prod = PROD_W'(length_acc_ff) * PROD_W'(10)
                   + PROD_W'(data_byte[3:0]);

   // atoi-style length parse, one byte per step
   always_comb begin
      acc_upd     = length_acc_ff;
      started_upd = started_ff;
      neg_upd     = neg_ff;
      stopped_upd = stopped_ff;
      if (!stopped_ff) begin
         if (is_digit) begin
            started_upd = 1'b1;
            acc_upd = (acc_prod > PROD_W'(ACC_MAX)) ? ACC_MAX : acc_prod[LEN_W-1:0];
         end else if (!started_ff && is_blank) begin
            started_upd = started_ff;
         end else if (!started_ff && is_sign) begin
            started_upd = 1'b1;
            neg_upd     = (data_byte == 8'h2D);
         end else begin
            stopped_upd = 1'b1;
         end
      end
   end

   assign magic_bad = (data_byte != MAGIC_WORD[field_pos_ff]);
   assign len_done  = (field_pos_ff == POS_W'(LEN_DIGITS - 1));
   assign len_bad   = neg_upd || (acc_upd == '0) || (acc_upd > max_body_len);
   assign body_last = (body_left_ff <= LEN_W'(1));

   // next state
   always_comb begin
      phase_in      = phase_ff;
      field_pos_in  = field_pos_ff;
      length_acc_in = length_acc_ff;
      started_in    = started_ff;
      neg_in        = neg_ff;
      stopped_in    = stopped_ff;
      body_left_in  = body_left_ff;
      case (phase_ff)
         PH_MAGIC: begin
            if (magic_bad) begin
               phase_in     = chunk_end ? PH_MAGIC : PH_DROP;
               field_pos_in = '0;
            end else if (field_pos_ff == POS_W'(MAGIC_LEN - 1)) begin
               phase_in      = PH_LEN;
               field_pos_in  = '0;
               length_acc_in = '0;
               started_in    = 1'b0;
               neg_in        = 1'b0;
               stopped_in    = 1'b0;
            end else begin
               field_pos_in = field_pos_ff + POS_W'(1);
            end
         end
         PH_LEN: begin
            length_acc_in = acc_upd;
            started_in    = started_upd;
            neg_in        = neg_upd;
            stopped_in    = stopped_upd;
            if (!len_done) begin
               field_pos_in = field_pos_ff + POS_W'(1);
            end else if (len_bad) begin
               phase_in      = chunk_end ? PH_MAGIC : PH_DROP;
               field_pos_in  = '0;
               length_acc_in = '0;
               started_in    = 1'b0;
               neg_in        = 1'b0;
               stopped_in    = 1'b0;
            end else begin
               body_left_in = acc_upd;
               phase_in     = PH_BODY;
               field_pos_in = '0;
            end
         end
         PH_BODY: begin
            body_left_in = body_last ? '0 : body_left_ff - LEN_W'(1);
            if (body_last) begin
               phase_in      = PH_MAGIC;
               field_pos_in  = '0;
               length_acc_in = '0;
               started_in    = 1'b0;
               neg_in        = 1'b0;
               stopped_in    = 1'b0;
            end
         end
         PH_DROP: begin
            if (chunk_end) begin
               phase_in      = PH_MAGIC;
               field_pos_in  = '0;
               length_acc_in = '0;
               started_in    = 1'b0;
               neg_in        = 1'b0;
               stopped_in    = 1'b0;
            end
         end
         default: phase_in = PH_MAGIC;
      endcase
   end

   // result of this step
   always_comb begin
      result = '0;
      case (phase_ff)
         PH_MAGIC: begin
            if (magic_bad) begin
               result.valid = 1'b1;
               result.kind  = KIND_ERROR;
            end
         end
         PH_LEN: begin
            if (len_done && len_bad) begin
               result.valid = 1'b1;
               result.kind  = KIND_ERROR;
            end
         end
         PH_BODY: begin
            if (connected) begin
               result.valid      = 1'b1;
               result.kind       = KIND_BODY;
               result.body_byte  = data_byte;
               result.frame_last = body_last;
            end
         end
         default: result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         field_pos_ff  <= '0;
         length_acc_ff <= '0;
         started_ff    <= 1'b0;
         neg_ff        <= 1'b0;
         stopped_ff    <= 1'b0;
         body_left_ff  <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         field_pos_ff  <= field_pos_in;
         length_acc_ff <= length_acc_in;
         started_ff    <= started_in;
         neg_ff        <= neg_in;
         stopped_ff    <= stopped_in;
         body_left_ff  <= body_left_in;
      end
   end

   `AST_IMP(a_body_nonempty, clock, reset, phase_ff == PH_BODY, body_left_ff != '0)
   `AST_IMP(a_pos_in_field, clock, reset, phase_ff == PH_LEN,
            field_pos_ff <= POS_W'(LEN_DIGITS - 1))
   `AST_IMP(a_drop_silent, clock, reset, phase_ff == PH_DROP, !result.valid)

endmodule

// ===== hdl/magic_length_frame_deframer.sv =====
// Deframer for a received byte stream: each frame is a five-byte magic word, a
// four-byte ASCII decimal length (parsed like atoi) and that many body bytes.
// req channel: one received byte per word in req_tdata, req_tlast marks the
// last byte of a receive chunk. rsp channel: body bytes in rsp_tdata with
// rsp_tlast on the final byte of a frame, or a header error word with
// rsp_tuser set and zero data, after which bytes are dropped to chunk end.
// csr port: index 0 is max_body_len, index 1 is connected (0 swallows body).
// Throughput is one byte per cycle while rsp_tready stays high. A byte is
// held in the input register and is parsed into the output register when
// the parser steps; its result word is presented on rsp from there. The
// input register lets a byte be taken while a result still waits on
// rsp_tready; when the receiver stalls longer both registers fill and
// req_tready drops. Reset (synchronous) empties both registers, returns the
// parser to magic search and loads max_body_len 9999 and connected 1.
`include "assert_macros.svh"

module magic_length_frame_deframer import mlfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tlast,   // chunk_end
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] body_byte
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast,   // frame_last
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [LEN_W-1:0] csr_wdata
);

   localparam logic CSR_MAX_LEN   = 1'b0;
   localparam logic CSR_CONNECTED = 1'b1;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_end_ff;
   logic             out_valid_ff;
   result_type       out_ff;
   logic [LEN_W-1:0] max_len_ff;
   logic             connected_ff;
   logic             step;
   result_type       result;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   mlfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step),
      .data_byte    (in_byte_ff),
      .chunk_end    (in_end_ff),
      .max_body_len (max_len_ff),
      .connected    (connected_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= result.valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         out_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= LEN_W'(9999);
         connected_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_LEN:   max_len_ff   <= csr_wdata;
            CSR_CONNECTED: connected_ff <= csr_wdata[0];
            default:       connected_ff <= connected_ff;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.body_byte;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.frame_last;

   `AST_IMP(a_error_word_clean, clock, reset, out_valid_ff && out_ff.kind == KIND_ERROR,
            out_ff.body_byte == 8'h00 && !out_ff.frame_last)
   `AST_NEXT(a_result_lands, clock, reset, step && result.valid, out_valid_ff)
   `AST_NEXT(a_stall_holds_input, clock, reset, in_valid_ff && !step, in_valid_ff)

endmodule
